@@ sv/irr_pkg.sv @@
// ----------------------------------------------------------------------------
// irr_pkg
// Shared types and constants of the IRQ redirection router.
// ----------------------------------------------------------------------------
package irr_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_CTRL = 2'd0,
    CMD_ADD_OVR  = 2'd1,
    CMD_SET_IRQ  = 2'd2,
    CMD_MASK_IRQ = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  localparam int unsigned CtrlIdxW   = 3;
  localparam int unsigned RegIdxW    = 10;
  localparam int unsigned EntriesW   = 9;
  localparam int unsigned OffsetW    = 8;
  localparam logic [RegIdxW-1:0] TableStart = 10'd16;
  localparam int unsigned MaskBit    = 16;
  localparam int unsigned PolBit     = 13;
  localparam int unsigned TrigBit    = 15;
  localparam int unsigned DestShift  = 24;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_SET   = 1'b1
  } kind_e;

  typedef struct packed {
    logic                active;
    logic                found;
    logic [31:0]         gsi;
    logic [CtrlIdxW-1:0] idx;
    logic [OffsetW-1:0]  offset;
  } token_t;

  typedef struct packed {
    logic                en;
    logic [31:0]         base;
    logic [EntriesW-1:0] entries;
  } ctrl_wr_t;

endpackage

@@ sv/irr_override_table.sv @@
// ----------------------------------------------------------------------------
// irr_override_table
// Remapping table for low IRQ numbers with polarity and trigger flags.
// ----------------------------------------------------------------------------
module irr_override_table
  import irr_pkg::*;
#(
  parameter int unsigned OVERRIDE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [7:0]  wr_irq_i,
  input  logic [31:0] wr_gsi_i,
  input  logic [15:0] wr_flags_i,
  input  logic [7:0]  rd_irq_i,
  output logic [31:0] rd_gsi_o,
  output logic [15:0] rd_flags_o
);

  localparam int unsigned IdxW = (OVERRIDE_DEPTH > 1) ? $clog2(OVERRIDE_DEPTH) : 1;

  logic [OVERRIDE_DEPTH-1:0] valid_q;
  logic [31:0]               gsi_q   [OVERRIDE_DEPTH];
  logic [15:0]               flags_q [OVERRIDE_DEPTH];

  logic            wr_in_range;
  logic            rd_in_range;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;

  assign wr_in_range = {1'b0, wr_irq_i} < 9'(OVERRIDE_DEPTH);
  assign rd_in_range = {1'b0, rd_irq_i} < 9'(OVERRIDE_DEPTH);
  assign wr_idx      = wr_irq_i[IdxW-1:0];
  assign rd_idx      = rd_irq_i[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i && wr_in_range) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      gsi_q[wr_idx]   <= wr_gsi_i;
      flags_q[wr_idx] <= wr_flags_i;
    end
  end

  always_comb begin
    rd_gsi_o   = {24'b0, rd_irq_i};
    rd_flags_o = '0;
    if (rd_in_range && valid_q[rd_idx]) begin
      rd_gsi_o   = gsi_q[rd_idx];
      rd_flags_o = flags_q[rd_idx];
    end
  end

endmodule

@@ sv/irr_cell.sv @@
// ----------------------------------------------------------------------------
// irr_cell
// One controller slot: holds a GSI range and checks the passing search token.
// ----------------------------------------------------------------------------
module irr_cell
  import irr_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ctrl_wr_t wr_i,
  input  logic     enabled_i,
  input  token_t   token_i,
  output token_t   token_o
);

  logic [31:0]         base_q;
  logic [EntriesW-1:0] entries_q;
  token_t              token_q;
  token_t              token_d;
  logic [32:0]         diff;
  logic                hit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      base_q    <= wr_i.base;
      entries_q <= wr_i.entries;
    end
  end

  assign diff = {1'b0, token_i.gsi} - {1'b0, base_q};
  assign hit  = enabled_i && !diff[32] && (diff[31:0] < {23'b0, entries_q});

  always_comb begin
    token_d = token_i;
    if (token_i.active && !token_i.found && hit) begin
      token_d.found  = 1'b1;
      token_d.idx    = CtrlIdxW'(CELL_IDX);
      token_d.offset = diff[OffsetW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
    end else begin
      token_q <= token_d;
    end
  end

  assign token_o = token_q;

endmodule

@@ sv/irq_redirection_router_unit.sv @@
// ----------------------------------------------------------------------------
// irq_redirection_router_unit
// Routes legacy IRQs to redirection-table register accesses of stored
// interrupt controllers.
// ----------------------------------------------------------------------------
// The input channel carries commands. A transfer takes place when in_valid_i
// is high and in_stall_o is low. Add-controller and add-override commands are
// absorbed in the cycle of their transfer and the block is ready again in the
// next cycle. Set-irq and mask-irq commands, taken while at least one
// controller is stored, send a search token through a chain of
// MAX_CONTROLLERS cells, one cell per cycle. Once the token leaves the
// last cell with a route, the accesses (three for a set, one for a mask)
// leave through an output register, one per cycle while out_stall_i is
// low. After a command without a route the block is idle with no access;
// one taken with no controller stored is dropped. While the receiver stalls,
// the pending access holds its value and the remaining accesses wait. Reset
// empties the controller list and restores the identity override mapping.
// ----------------------------------------------------------------------------
module irq_redirection_router_unit
  import irr_pkg::*;
#(
  parameter int unsigned MAX_CONTROLLERS = 8,
  parameter int unsigned OVERRIDE_DEPTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          irq_i,
  input  logic [7:0]          vector_i,
  input  logic [7:0]          dest_id_i,
  input  logic [31:0]         gsi_value_i,
  input  logic [15:0]         override_flags_i,
  input  logic [31:0]         version_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CtrlIdxW-1:0] controller_index_o,
  output logic [RegIdxW-1:0]  register_index_o,
  output logic [31:0]         write_data_o,
  output logic                access_kind_o,
  output logic                last_o
);

  localparam int unsigned CntW = $clog2(MAX_CONTROLLERS + 1);

  state_e state_q, state_d;
  cmd_e   cmd;
  logic   accept;
  logic   launch;

  logic [CntW-1:0] count_q;
  logic            add_ctrl;
  logic            add_ovr;

  logic [31:0] ovr_gsi;
  logic [15:0] ovr_flags;

  token_t tokens [MAX_CONTROLLERS+1];

  logic                is_mask_q;
  logic [31:0]         low_q;
  logic [7:0]          dest_q;
  logic [CtrlIdxW-1:0] idx_q;
  logic [RegIdxW-1:0]  reg_q;
  logic [1:0]          beat_q, beat_d;
  logic                route_en;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [CtrlIdxW-1:0] out_idx_q;
  logic [RegIdxW-1:0]  out_reg_q, out_reg_d;
  logic [31:0]         out_data_q, out_data_d;
  kind_e               out_kind_q, out_kind_d;
  logic                out_last_q, out_last_d;

  assign cmd        = cmd_e'(command_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign add_ctrl   = accept && (cmd == CMD_ADD_CTRL);
  assign add_ovr    = accept && (cmd == CMD_ADD_OVR);
  assign launch     = accept && (cmd == CMD_SET_IRQ || cmd == CMD_MASK_IRQ) &&
                      (count_q != '0);

  irr_override_table #(
    .OVERRIDE_DEPTH(OVERRIDE_DEPTH)
  ) u_override (
    .clk_i,
    .rst_ni,
    .wr_en_i   (add_ovr),
    .wr_irq_i  (irq_i),
    .wr_gsi_i  (gsi_value_i),
    .wr_flags_i(override_flags_i),
    .rd_irq_i  (irq_i),
    .rd_gsi_o  (ovr_gsi),
    .rd_flags_o(ovr_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (add_ctrl && (count_q < CntW'(MAX_CONTROLLERS))) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_comb begin
    tokens[0]        = '0;
    tokens[0].active = launch;
    tokens[0].gsi    = ovr_gsi;
  end

  for (genvar i = 0; i < MAX_CONTROLLERS; i++) begin : g_cell
    ctrl_wr_t wr;
    logic     enabled;

    assign enabled    = CntW'(i) < count_q;
    assign wr.en      = add_ctrl && (count_q == CntW'(i));
    assign wr.base    = gsi_value_i;
    assign wr.entries = {1'b0, version_word_i[23:16]} + 9'd1;

    irr_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .wr_i     (wr),
      .enabled_i(enabled),
      .token_i  (tokens[i]),
      .token_o  (tokens[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      is_mask_q <= (cmd == CMD_MASK_IRQ);
      dest_q    <= dest_id_i;
      low_q     <= {16'b0, (ovr_flags[3:2] == 2'b11), 1'b0, (ovr_flags[1:0] == 2'b11),
                    5'b0, vector_i};
    end
    if (route_en) begin
      idx_q <= tokens[MAX_CONTROLLERS].idx;
      reg_q <= TableStart + {1'b0, tokens[MAX_CONTROLLERS].offset, 1'b0};
    end
  end

  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    beat_d      = beat_q;
    route_en    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_reg_d   = reg_q;
    out_data_d  = low_q;
    out_kind_d  = KIND_WRITE;
    out_last_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (launch) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        beat_d = 2'd0;
        if (tokens[MAX_CONTROLLERS].active) begin
          if (tokens[MAX_CONTROLLERS].found) begin
            route_en = 1'b1;
            state_d  = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (is_mask_q) begin
          out_data_d = 32'b1 << MaskBit;
          out_kind_d = KIND_SET;
          out_last_d = 1'b1;
        end else begin
          case (beat_q)
            2'd0: begin
              out_data_d = low_q | (32'b1 << MaskBit);
            end
            2'd1: begin
              out_reg_d  = reg_q + 1'b1;
              out_data_d = {24'b0, dest_q} << DestShift;
            end
            default: begin
              out_last_d = 1'b1;
            end
          endcase
        end
        if (out_load) begin
          out_valid_d = 1'b1;
          beat_d      = beat_q + 1'b1;
          if (out_last_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      beat_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_load) begin
      out_idx_q  <= idx_q;
      out_reg_q  <= out_reg_d;
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign controller_index_o = out_idx_q;
  assign register_index_o   = out_reg_q;
  assign write_data_o       = out_data_q;
  assign access_kind_o      = out_kind_q;
  assign last_o             = out_last_q;

endmodule

@@ test/tb_irq_redirection_router_unit.sv @@
// ----------------------------------------------------------------------------
// tb_irq_redirection_router_unit
// Drives directed and random routing commands into the IRQ redirection
// router with random gaps on the command side and random stalls on the
// access side. Every register access that leaves the block is compared
// with the directed table or with a routing model held in this bench.
// ----------------------------------------------------------------------------
module tb_irq_redirection_router_unit;
  import irr_pkg::*;

  localparam int unsigned NumCtrl     = 8;
  localparam int unsigned NumOverride = 16;
  localparam int          Predicted   = -1;
  localparam int          NumRandom   = 330;
  localparam int          IdleLimit   = 3000;
  localparam int          DrainCycles = 2 * NumCtrl + 8;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  irq;
    logic [7:0]  vector;
    logic [7:0]  dest_id;
    logic [31:0] gsi;
    logic [15:0] oflags;
    logic [31:0] version;
  } command_t;

  typedef struct {
    cmd_e               cmd;
    logic [7:0]         irq;
    logic [7:0]         vector;
    logic [7:0]         dest_id;
    logic [31:0]        gsi;
    logic [15:0]        oflags;
    logic [31:0]        version;
    int                 n_typed;
    logic [CtrlIdxW-1:0] t_ctl;
    logic [RegIdxW-1:0]  t_reg;
  } dir_row_t;

  typedef struct {
    logic [CtrlIdxW-1:0] ctl;
    logic [RegIdxW-1:0]  reg_idx;
    logic [31:0]         data;
    kind_e               kind;
    logic                last;
  } access_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          command_i;
  logic [7:0]          irq_i;
  logic [7:0]          vector_i;
  logic [7:0]          dest_id_i;
  logic [31:0]         gsi_value_i;
  logic [15:0]         override_flags_i;
  logic [31:0]         version_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CtrlIdxW-1:0] controller_index_o;
  logic [RegIdxW-1:0]  register_index_o;
  logic [31:0]         write_data_o;
  logic                access_kind_o;
  logic                last_o;

  logic [31:0]         ovr_gsi     [NumOverride];
  logic [15:0]         ovr_flags   [NumOverride];
  logic [31:0]         ctl_base    [NumCtrl];
  logic [EntriesW-1:0] ctl_entries [NumCtrl];
  int                  ctl_count;

  access_t             pending_accesses [$];
  dir_row_t            directed_rows [26];
  int                  fail_count;
  bit                  calm;

  irq_redirection_router_unit #(
    .MAX_CONTROLLERS(NumCtrl),
    .OVERRIDE_DEPTH (NumOverride)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .irq_i             (irq_i),
    .vector_i          (vector_i),
    .dest_id_i         (dest_id_i),
    .gsi_value_i       (gsi_value_i),
    .override_flags_i  (override_flags_i),
    .version_word_i    (version_word_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .controller_index_o(controller_index_o),
    .register_index_o  (register_index_o),
    .write_data_o      (write_data_o),
    .access_kind_o     (access_kind_o),
    .last_o            (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int pct;
    pct = $urandom_range(0, 99);
    if (calm || pct < 55) return 0;
    if (pct < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic route_command(input command_t c, output access_t acc [3], output int n);
    logic [31:0] gsi;
    logic [15:0] flags;
    logic [31:0] low;
    logic [31:0] offset;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [RegIdxW-1:0] reg_idx;
    logic [CtrlIdxW-1:0] ctl;
    bit hit;
    n = 0;
    hit = 1'b0;
    ctl = '0;
    reg_idx = '0;
    case (c.cmd)
      CMD_ADD_CTRL: begin
        if (ctl_count < NumCtrl) begin
          ctl_base[ctl_count] = c.gsi;
          ctl_entries[ctl_count] = EntriesW'(c.version[23:16]) + 1'b1;
          ctl_count++;
        end
      end
      CMD_ADD_OVR: begin
        if (c.irq < NumOverride) begin
          ovr_gsi[c.irq] = c.gsi;
          ovr_flags[c.irq] = c.oflags;
        end
      end
      default: begin
        if (c.irq < NumOverride) begin
          gsi = ovr_gsi[c.irq];
          flags = ovr_flags[c.irq];
        end else begin
          gsi = {24'd0, c.irq};
          flags = '0;
        end
        for (int i = 0; i < ctl_count && !hit; i++) begin
          lo = {32'd0, ctl_base[i]};
          hi = lo + 64'(ctl_entries[i]);
          if ({32'd0, gsi} >= lo && {32'd0, gsi} < hi) begin
            hit = 1'b1;
            ctl = CtrlIdxW'(i);
            offset = gsi - ctl_base[i];
            reg_idx = TableStart + RegIdxW'(offset << 1);
          end
        end
        if (hit && c.cmd == CMD_SET_IRQ) begin
          low = {24'd0, c.vector};
          if (flags[1:0] == 2'b11) low[PolBit] = 1'b1;
          if (flags[3:2] == 2'b11) low[TrigBit] = 1'b1;
          acc[0] = '{ctl, reg_idx, low | (32'd1 << MaskBit), KIND_WRITE, 1'b0};
          acc[1] = '{ctl, reg_idx + 1'b1, {c.dest_id, 24'd0}, KIND_WRITE, 1'b0};
          acc[2] = '{ctl, reg_idx, low, KIND_WRITE, 1'b1};
          n = 3;
        end else if (hit) begin
          acc[0] = '{ctl, reg_idx, 32'd1 << MaskBit, KIND_SET, 1'b1};
          n = 1;
        end
      end
    endcase
  endtask

  function automatic command_t random_command();
    command_t c;
    int pct;
    int sel;
    c.irq = 8'($urandom);
    c.vector = 8'($urandom);
    c.dest_id = 8'($urandom);
    c.gsi = $urandom;
    c.oflags = 16'($urandom);
    c.version = $urandom;
    pct = $urandom_range(0, 99);
    if (pct < 8) begin
      c.cmd = CMD_ADD_CTRL;
    end else if (pct < 38) begin
      c.cmd = CMD_ADD_OVR;
      if ($urandom_range(0, 9) != 0) c.irq = 8'($urandom_range(0, NumOverride - 1));
      if ($urandom_range(0, 3) != 0 && ctl_count > 0) begin
        sel = $urandom_range(0, ctl_count - 1);
        c.gsi = ctl_base[sel] + $urandom_range(0, ctl_entries[sel]);
      end
    end else begin
      c.cmd = (pct < 72) ? CMD_SET_IRQ : CMD_MASK_IRQ;
      if ($urandom_range(0, 9) < 6) c.irq = 8'($urandom_range(0, NumOverride - 1));
    end
    return c;
  endfunction

  task automatic send_command(input command_t c, input int n_typed,
                              input logic [CtrlIdxW-1:0] t_ctl,
                              input logic [RegIdxW-1:0] t_reg);
    int gap;
    int n;
    access_t acc [3];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i        <= c.cmd;
    irq_i            <= c.irq;
    vector_i         <= c.vector;
    dest_id_i        <= c.dest_id;
    gsi_value_i      <= c.gsi;
    override_flags_i <= c.oflags;
    version_word_i   <= c.version;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    route_command(c, acc, n);
    if (n_typed == Predicted) begin
      for (int i = 0; i < n; i++) pending_accesses.push_back(acc[i]);
    end else if (n_typed == 1) begin
      pending_accesses.push_back('{t_ctl, t_reg, 32'd1 << MaskBit, KIND_SET, 1'b1});
    end
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    access_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_accesses.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected access: ctl %0d reg %0d data %h kind %0d last %0d",
                   controller_index_o, register_index_o, write_data_o,
                   access_kind_o, last_o);
      end else begin
        e = pending_accesses.pop_front();
        if (controller_index_o !== e.ctl || register_index_o !== e.reg_idx ||
            write_data_o !== e.data || access_kind_o !== e.kind || last_o !== e.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp ctl %0d reg %0d data %h kind %0d last %0d, %s",
                     e.ctl, e.reg_idx, e.data, e.kind, e.last,
                     $sformatf("got ctl %0d reg %0d data %h kind %0d last %0d",
                               controller_index_o, register_index_o, write_data_o,
                               access_kind_o, last_o));
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stall_gen
    int gap;
    int run;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      run = $urandom_range(1, 12);
      repeat (run) @(negedge clk_i);
    end
  end

  initial begin : main
    command_t c;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    command_i        <= '0;
    irq_i            <= '0;
    vector_i         <= '0;
    dest_id_i        <= '0;
    gsi_value_i      <= '0;
    override_flags_i <= '0;
    version_word_i   <= '0;
    fail_count = 0;
    calm = 1'b0;
    ctl_count = 0;
    for (int i = 0; i < NumOverride; i++) begin
      ovr_gsi[i] = 32'(i);
      ovr_flags[i] = '0;
    end
    for (int i = 0; i < NumCtrl; i++) begin
      ctl_base[i] = '0;
      ctl_entries[i] = '0;
    end
    directed_rows = '{
      '{CMD_SET_IRQ,  8'd3,   8'h12, 8'h34, 32'h0000_0000, 16'h0000, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h0000_0000, 16'h0000, 32'h0017_0011,
        0, 3'd0, 10'd0},
      '{CMD_MASK_IRQ, 8'd0,   8'h00, 8'h00, 32'h0000_0000, 16'h0000, 32'h0, 1, 3'd0, 10'd16},
      '{CMD_SET_IRQ,  8'd0,   8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, Predicted,
        3'd0, 10'd0},
      '{CMD_SET_IRQ,  8'd23,  8'h00, 8'h00, 32'h0000_0000, 16'h0000, 32'h0, Predicted,
        3'd0, 10'd0},
      '{CMD_SET_IRQ,  8'd24,  8'h5A, 8'hA5, 32'h0000_0000, 16'h0000, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'hFFFF_FF00, 16'h0000, 32'h00FF_0000,
        0, 3'd0, 10'd0},
      '{CMD_ADD_OVR,  8'd15,  8'h00, 8'h00, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_SET_IRQ,  8'd15,  8'h80, 8'h00, 32'h0000_0000, 16'h0000, 32'h0, Predicted,
        3'd0, 10'd0},
      '{CMD_MASK_IRQ, 8'd15,  8'h00, 8'h00, 32'h0000_0000, 16'h0000, 32'h0, 1, 3'd1, 10'd526},
      '{CMD_ADD_OVR,  8'd16,  8'h00, 8'h00, 32'h0000_0005, 16'h000F, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_SET_IRQ,  8'd16,  8'h55, 8'hAA, 32'h0000_0000, 16'h0000, 32'h0, Predicted,
        3'd0, 10'd0},
      '{CMD_ADD_OVR,  8'd2,   8'h00, 8'h00, 32'h0000_03E8, 16'h000C, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_SET_IRQ,  8'd2,   8'h11, 8'h22, 32'h0000_0000, 16'h0000, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF,
        0, 3'd0, 10'd0},
      '{CMD_SET_IRQ,  8'd255, 8'h00, 8'h80, 32'h0000_0000, 16'h0000, 32'h0, Predicted,
        3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h0000_0100, 16'h0000, 32'h0000_FFFF,
        0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h8000_0000, 16'h0000, 32'hFF0F_0000,
        0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h0000_1000, 16'h0000, 32'h003F_0000,
        0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h0001_0000, 16'h0000, 32'h0007_0000,
        0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h7FFF_FFF8, 16'h0000, 32'h0010_0000,
        0, 3'd0, 10'd0},
      '{CMD_ADD_CTRL, 8'd0,   8'h00, 8'h00, 32'h0000_0200, 16'h0000, 32'h00FF_0000,
        0, 3'd0, 10'd0},
      '{CMD_ADD_OVR,  8'd0,   8'h00, 8'h00, 32'h0000_0200, 16'h0000, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_SET_IRQ,  8'd0,   8'h33, 8'h44, 32'h0000_0000, 16'h0000, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_ADD_OVR,  8'd4,   8'h00, 8'h00, 32'h7FFF_FFFF, 16'h0003, 32'h0, 0, 3'd0, 10'd0},
      '{CMD_MASK_IRQ, 8'd4,   8'h00, 8'h00, 32'h0000_0000, 16'h0000, 32'h0, 1, 3'd7, 10'd30}
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      c = '{directed_rows[i].cmd, directed_rows[i].irq, directed_rows[i].vector,
            directed_rows[i].dest_id, directed_rows[i].gsi, directed_rows[i].oflags,
            directed_rows[i].version};
      send_command(c, directed_rows[i].n_typed, directed_rows[i].t_ctl,
                   directed_rows[i].t_reg);
    end

    for (int k = 0; k < NumRandom; k++) begin
      calm = ((k / 40) % 4 == 3);
      c = random_command();
      send_command(c, Predicted, '0, '0);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_accesses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    fail_count += pending_accesses.size();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/irr_pkg.sv
sv/irr_override_table.sv
sv/irr_cell.sv
sv/irq_redirection_router_unit.sv
test/tb_irq_redirection_router_unit.sv
